@@ src/mted_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Manchester edge time decoder package
// Shared widths, register map, reset values and the types that travel
// between the register file, the classifier, the queue and the decoder.
// ---------------------------------------------------------------------------
package mted_pkg;

   // Field widths.
   localparam int TIME_BITS  = 16;
   localparam int BYTE_BITS  = 8;
   localparam int INDEX_BITS = 3;
   localparam int COUNT_BITS = BYTE_BITS + INDEX_BITS;

   // Register port widths.
   localparam int ADDR_BITS = 4;
   localparam int DATA_BITS = 32;

   // Queue between the classifier and the decoder.
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Register reset values.
   localparam logic [TIME_BITS-1:0] CLOCK_2T_RESET     = 16'd256;
   localparam logic [TIME_BITS-1:0] EDGE_TIMEOUT_RESET = 16'd4096;
   localparam logic [BYTE_BITS-1:0] MAX_BYTES_RESET    = 8'd8;

   // Register index, taken from the word address.
   typedef enum logic [1:0] {
      REG_CLOCK_2T     = 2'd0,
      REG_EDGE_TIMEOUT = 2'd1,
      REG_MAX_BYTES    = 2'd2
   } reg_index_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [TIME_BITS-1:0] clock_2t;
      logic [TIME_BITS-1:0] edge_timeout;
      logic [BYTE_BITS-1:0] max_bytes;
   } csr_type;

   // One classified edge interval.
   typedef struct packed {
      logic start;
      logic init_bit;
      logic is_short;
      logic is_long;
   } item_class_type;

endpackage

@@ src/mted_csr.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Register file
// Holds the bit period, the maximum edge length and the byte limit, written
// and read through the APB-style port.
// ---------------------------------------------------------------------------
module mted_csr
   import mted_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output csr_type              csr
);

   logic [TIME_BITS-1:0] clock_2t_ff;
   logic [TIME_BITS-1:0] clock_2t_in;
   logic [TIME_BITS-1:0] edge_timeout_ff;
   logic [TIME_BITS-1:0] edge_timeout_in;
   logic [BYTE_BITS-1:0] max_bytes_ff;
   logic [BYTE_BITS-1:0] max_bytes_in;
   logic                 write_en;
   reg_index_type        index;

   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite;
   assign index    = reg_index_type'(paddr[3:2]);

   // Next register values on a write transfer.
   always_comb begin
      clock_2t_in     = clock_2t_ff;
      edge_timeout_in = edge_timeout_ff;
      max_bytes_in    = max_bytes_ff;
      if (write_en) begin
         case (index)
            REG_CLOCK_2T:     clock_2t_in     = pwdata[TIME_BITS-1:0];
            REG_EDGE_TIMEOUT: edge_timeout_in = pwdata[TIME_BITS-1:0];
            REG_MAX_BYTES:    max_bytes_in    = pwdata[BYTE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_2t_ff     <= CLOCK_2T_RESET;
         edge_timeout_ff <= EDGE_TIMEOUT_RESET;
         max_bytes_ff    <= MAX_BYTES_RESET;
      end else begin
         clock_2t_ff     <= clock_2t_in;
         edge_timeout_ff <= edge_timeout_in;
         max_bytes_ff    <= max_bytes_in;
      end
   end

   // Read data.
   always_comb begin
      case (index)
         REG_CLOCK_2T:     prdata = {{(DATA_BITS-TIME_BITS){1'b0}}, clock_2t_ff};
         REG_EDGE_TIMEOUT: prdata = {{(DATA_BITS-TIME_BITS){1'b0}}, edge_timeout_ff};
         REG_MAX_BYTES:    prdata = {{(DATA_BITS-BYTE_BITS){1'b0}}, max_bytes_ff};
         default:          prdata = '0;
      endcase
   end

   assign csr.clock_2t     = clock_2t_ff;
   assign csr.edge_timeout = edge_timeout_ff;
   assign csr.max_bytes    = max_bytes_ff;

endmodule

@@ src/mted_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Interval classifier
// Accepts edge intervals and sorts each into short, long or out of window
// against limits derived from the bit period.
// ---------------------------------------------------------------------------
module mted_front
   import mted_pkg::*;
(
   input  csr_type              csr,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TIME_BITS-1:0] req_edge_duration,
   input  logic                 req_frame_start,
   input  logic                 req_initial_bit,
   input  logic                 queue_full,
   output logic                 push,
   output item_class_type       push_item
);

   logic [TIME_BITS+1:0] times3;
   logic [TIME_BITS+2:0] times5;
   logic [TIME_BITS-3:0] short_lo;
   logic [TIME_BITS-1:0] short_hi;
   logic [TIME_BITS:0]   long_hi;
   logic                 in_range;

   assign req_ready = ~queue_full;
   assign push      = req_valid & ~queue_full;

   // Window limits: 2T/4, 3*2T/4 and 5*2T/4, each rounded down.
   assign times3   = {1'b0, csr.clock_2t, 1'b0} + {2'b00, csr.clock_2t};
   assign times5   = {1'b0, csr.clock_2t, 2'b00} + {3'b000, csr.clock_2t};
   assign short_lo = csr.clock_2t[TIME_BITS-1:2];
   assign short_hi = times3[TIME_BITS+1:2];
   assign long_hi  = times5[TIME_BITS+2:2];

   assign in_range = req_edge_duration < csr.edge_timeout;

   // Both windows are exclusive at each end.
   assign push_item.start    = req_frame_start;
   assign push_item.init_bit = req_initial_bit;
   assign push_item.is_short = in_range
                             & (req_edge_duration > {2'b00, short_lo})
                             & (req_edge_duration < short_hi);
   assign push_item.is_long  = in_range
                             & (req_edge_duration > short_hi)
                             & ({1'b0, req_edge_duration} < long_hi);

endmodule

@@ src/mted_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Classified item queue
// A short first-in first-out queue between the classifier and the decoder.
// ---------------------------------------------------------------------------
module mted_queue
   import mted_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  item_class_type push_item,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output item_class_type head_item
);

   item_class_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]     wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]     wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]     rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]     rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]     count_ff;
   logic [QUEUE_CNT_BITS-1:0]     count_in;

   localparam logic [QUEUE_CNT_BITS-1:0] FULL_COUNT = QUEUE_CNT_BITS'(QUEUE_DEPTH);
   localparam logic [QUEUE_PTR_BITS-1:0] LAST_PTR   = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ src/mted_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bit decoder
// Turns classified intervals into bits, packs them into bytes MSB first and
// drives the registered result channel.
// ---------------------------------------------------------------------------
module mted_back
   import mted_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  csr_type               csr,
   input  logic                  head_valid,
   input  item_class_type        head_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTE_BITS-1:0]  rsp_data_byte,
   output logic [COUNT_BITS-1:0] rsp_bits_received,
   output logic                  rsp_desync,
   output logic                  rsp_last
);

   // Decoder state.
   logic                  frame_active_ff;
   logic                  frame_active_in;
   logic                  previous_bit_ff;
   logic                  previous_bit_in;
   logic                  pending_short_ff;
   logic                  pending_short_in;
   logic [BYTE_BITS-1:0]  shift_byte_ff;
   logic [BYTE_BITS-1:0]  shift_byte_in;
   logic [INDEX_BITS-1:0] bit_index_ff;
   logic [INDEX_BITS-1:0] bit_index_in;
   logic [BYTE_BITS-1:0]  byte_count_ff;
   logic [BYTE_BITS-1:0]  byte_count_in;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [BYTE_BITS-1:0]  data_byte_ff;
   logic [BYTE_BITS-1:0]  data_byte_in;
   logic [COUNT_BITS-1:0] bits_received_ff;
   logic [COUNT_BITS-1:0] bits_received_in;
   logic                  desync_ff;
   logic                  desync_in;
   logic                  last_ff;
   logic                  last_in;

   logic [BYTE_BITS-1:0]  byte_limit;

   // A byte limit of zero acts as one.
   assign byte_limit = (csr.max_bytes == '0) ? BYTE_BITS'(1) : csr.max_bytes;

   // The head item is taken whenever the result register is free or drains.
   assign pop = head_valid & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      logic                 emit;
      logic                 fail;
      logic                 shift_bit;
      logic                 bit_value;
      logic [BYTE_BITS-1:0] next_shift;
      logic [BYTE_BITS-1:0] next_count;

      emit       = 1'b0;
      fail       = 1'b0;
      shift_bit  = 1'b0;
      bit_value  = 1'b0;
      next_shift = '0;
      next_count = '0;

      frame_active_in  = frame_active_ff;
      previous_bit_in  = previous_bit_ff;
      pending_short_in = pending_short_ff;
      shift_byte_in    = shift_byte_ff;
      bit_index_in     = bit_index_ff;
      byte_count_in    = byte_count_ff;

      data_byte_in     = data_byte_ff;
      bits_received_in = bits_received_ff;
      desync_in        = desync_ff;
      last_in          = last_ff;

      if (pop) begin
         // A frame start seeds a fresh frame, dropping any frame in progress.
         if (head_item.start) begin
            frame_active_in  = 1'b1;
            previous_bit_in  = head_item.init_bit;
            pending_short_in = 1'b0;
            shift_byte_in    = '0;
            bit_index_in     = '0;
            byte_count_in    = '0;
         end

         if (frame_active_in) begin
            // Decode: a long interval flips the bit, two shorts keep it.
            if (pending_short_in) begin
               pending_short_in = 1'b0;
               if (!head_item.is_short) begin
                  fail = 1'b1;
               end else begin
                  bit_value = previous_bit_in;
                  shift_bit = 1'b1;
               end
            end else if (head_item.is_long) begin
               bit_value = ~previous_bit_in;
               shift_bit = 1'b1;
            end else if (head_item.is_short) begin
               pending_short_in = 1'b1;
            end else begin
               fail = 1'b1;
            end

            if (fail) begin
               // Out of window or unpaired: report partial byte, end frame.
               emit             = 1'b1;
               data_byte_in     = shift_byte_in;
               bits_received_in = {byte_count_in, bit_index_in};
               desync_in        = 1'b1;
               last_in          = 1'b1;
               frame_active_in  = 1'b0;
               pending_short_in = 1'b0;
            end else if (shift_bit) begin
               next_shift      = {shift_byte_in[BYTE_BITS-2:0], bit_value};
               previous_bit_in = bit_value;
               if (bit_index_in == '1) begin
                  // Byte complete.
                  next_count       = byte_count_in + 1'b1;
                  emit             = 1'b1;
                  data_byte_in     = next_shift;
                  bits_received_in = {next_count, {INDEX_BITS{1'b0}}};
                  desync_in        = 1'b0;
                  last_in          = (next_count >= byte_limit);
                  shift_byte_in    = '0;
                  bit_index_in     = '0;
                  byte_count_in    = next_count;
                  if (next_count >= byte_limit) begin
                     frame_active_in = 1'b0;
                  end
               end else begin
                  shift_byte_in = next_shift;
                  bit_index_in  = bit_index_in + 1'b1;
               end
            end
         end
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_active_ff  <= 1'b0;
         previous_bit_ff  <= 1'b0;
         pending_short_ff <= 1'b0;
         shift_byte_ff    <= '0;
         bit_index_ff     <= '0;
         byte_count_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         frame_active_ff  <= frame_active_in;
         previous_bit_ff  <= previous_bit_in;
         pending_short_ff <= pending_short_in;
         shift_byte_ff    <= shift_byte_in;
         bit_index_ff     <= bit_index_in;
         byte_count_ff    <= byte_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      data_byte_ff     <= data_byte_in;
      bits_received_ff <= bits_received_in;
      desync_ff        <= desync_in;
      last_ff          <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_byte     = data_byte_ff;
   assign rsp_bits_received = bits_received_ff;
   assign rsp_desync        = desync_ff;
   assign rsp_last          = last_ff;

endmodule

@@ src/manchester_edge_time_decoder.sv @@
`timescale 1ns / 1ps
// Decodes a Manchester stream from measured times between edges. One edge
// interval is accepted per clock cycle while the queue has room; a
// classifier sorts it into short, long or out of window, and a two-entry
// queue carries it to the decoder, which loads any result into a registered
// output at the same edge at which it takes the item. A full byte yields one
// result; a frame ends after the byte limit, on an out-of-window interval or
// on a short that a second short does not follow. The sustained rate
// is one item per cycle as long as results are taken as they appear; a
// stalled result holds the decoder, and the queue then fills and drops
// req_ready.
// ---------------------------------------------------------------------------
// Manchester edge time decoder
// Top level: register file, interval classifier, queue and bit decoder.
// ---------------------------------------------------------------------------
module manchester_edge_time_decoder
   import mted_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TIME_BITS-1:0]  req_edge_duration,
   input  logic                  req_frame_start,
   input  logic                  req_initial_bit,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTE_BITS-1:0]  rsp_data_byte,
   output logic [COUNT_BITS-1:0] rsp_bits_received,
   output logic                  rsp_desync,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_BITS-1:0]  paddr,
   input  logic [DATA_BITS-1:0]  pwdata,
   output logic [DATA_BITS-1:0]  prdata,
   output logic                  pready
);

   csr_type        csr;
   logic           queue_full;
   logic           push;
   item_class_type push_item;
   logic           pop;
   logic           head_valid;
   item_class_type head_item;

   mted_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   mted_front u_front (
      .csr               (csr),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_edge_duration (req_edge_duration),
      .req_frame_start   (req_frame_start),
      .req_initial_bit   (req_initial_bit),
      .queue_full        (queue_full),
      .push              (push),
      .push_item         (push_item)
   );

   mted_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   mted_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr               (csr),
      .head_valid        (head_valid),
      .head_item         (head_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_bits_received (rsp_bits_received),
      .rsp_desync        (rsp_desync),
      .rsp_last          (rsp_last)
   );

endmodule
